[design/ton_pkg.sv]
// ----------------------------------------------------------------------------
// Telnet option negotiator package
// Shared byte codes, action codes, parser phases and the job descriptor that
// the front end hands to the back end.
// ----------------------------------------------------------------------------
package ton_pkg;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_NET   = 2'd1;
   localparam logic [1:0] ACT_KBD   = 2'd2;

   localparam logic [7:0] B_IAC  = 8'd255;
   localparam logic [7:0] B_WILL = 8'd251;
   localparam logic [7:0] B_WONT = 8'd252;
   localparam logic [7:0] B_DO   = 8'd253;
   localparam logic [7:0] B_DONT = 8'd254;
   localparam logic [7:0] B_CR   = 8'd13;
   localparam logic [7:0] B_LF   = 8'd10;
   localparam logic [7:0] OPT_ECHO = 8'd1;
   localparam logic [7:0] OPT_SGA  = 8'd3;

   localparam logic [7:0] TUNNEL_RESET = 8'd100;

   // Most bytes one input item can produce.
   localparam int unsigned MAX_BYTES = 6;

   typedef enum logic [2:0] {
      PH_NORMAL,
      PH_CR,
      PH_IAC,
      PH_WILL,
      PH_WONT,
      PH_DO,
      PH_DONT
   } phase_type;

   // One job: a run of bytes going the same way, emitted bytes[0] first.
   typedef struct packed {
      logic                            to_net;
      logic                            finished;
      logic [2:0]                      count;
      logic [MAX_BYTES-1:0][7:0]       bytes;
   } job_type;

endpackage

[design/telnet_option_negotiator_core.sv]
// ----------------------------------------------------------------------------
// Telnet option negotiator core
// Byte-level telnet engine: start requests, keyboard bytes and network bytes
// go in; bytes for the network peer or the terminal come out.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                         Handshake
//   -------   ---------------------------   ----------------------------------
//   request   req_action, req_data_byte     beat when req_push && !req_full
//   response  rsp_to_network, rsp_out_byte, beat when rsp_pop && !rsp_empty
//             rsp_last, rsp_finished
//   csr       csr_tunnel_option             written when csr_write_en is high
//
// A request beat is parsed in the cycle it is accepted, so a new request can
// be taken every cycle while the job queue has room. Each request yields zero
// to six response beats; the back end emits one response beat per cycle while
// the response side keeps popping, so the sustained rate is set by that side.
// The first response byte passes through the job queue slot and then the
// result register before it can be popped.
// Reset is synchronous: the parser returns to normal text, the finished latch
// clears, the tunnel option becomes 100 and all queues empty.
// A stalled response side fills the job queue and then raises req_full.
//
module telnet_option_negotiator_core #(
   parameter int unsigned JOB_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_action,
   input  logic [7:0] req_data_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_to_network,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic       rsp_finished,
   input  logic       csr_write_en,
   input  logic [7:0] csr_tunnel_option
);

   logic             req_accept;
   logic             front_valid;
   ton_pkg::job_type front_job;
   logic             head_valid;
   ton_pkg::job_type head_job;
   logic             head_pop;

   // A beat is taken whenever the job queue has a free slot; beats that
   // produce no bytes still pass through the parser to update its phase.
   assign req_accept = req_push && !req_full;

   ton_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_tunnel_option (csr_tunnel_option),
      .accept            (req_accept),
      .action            (req_action),
      .data_byte         (req_data_byte),
      .job_valid         (front_valid),
      .job               (front_job)
   );

   // The queue decouples parsing from byte emission so that a multi-byte
   // reply does not hold up the next request.
   ton_job_queue #(
      .DEPTH (JOB_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid),
      .push_job   (front_job),
      .full       (req_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // The back end holds one finished response beat in its output register
   // and refills it in the same cycle the beat is popped.
   ton_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (head_valid),
      .job            (head_job),
      .job_pop        (head_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_to_network (rsp_to_network),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .rsp_finished   (rsp_finished)
   );

endmodule

[design/ton_front.sv]
// ----------------------------------------------------------------------------
// Telnet option negotiator front end
// Takes input beats, runs the network parser and builds one job per beat.
// ----------------------------------------------------------------------------
module ton_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [7:0]       csr_tunnel_option,
   input  logic             accept,
   input  logic [1:0]       action,
   input  logic [7:0]       data_byte,
   output logic             job_valid,
   output ton_pkg::job_type job
);

   ton_pkg::phase_type phase_ff, phase_in;
   logic               done_ff, done_in;
   logic [7:0]         tunnel_ff;
   logic               is_net;

   assign is_net = (action == ton_pkg::ACT_NET) && !done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ton_pkg::PH_NORMAL;
         done_ff   <= 1'b0;
         tunnel_ff <= ton_pkg::TUNNEL_RESET;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            done_ff  <= done_in;
         end
         if (csr_write_en) begin
            tunnel_ff <= csr_tunnel_option;
         end
      end
   end

   // Parser next phase; only network bytes move it.
   always_comb begin
      phase_in = phase_ff;
      if (is_net) begin
         unique case (phase_ff) inside
            ton_pkg::PH_NORMAL, ton_pkg::PH_CR: begin
               if (phase_ff == ton_pkg::PH_CR && data_byte == ton_pkg::B_LF) begin
                  phase_in = ton_pkg::PH_NORMAL;
               end else if (data_byte == ton_pkg::B_CR) begin
                  phase_in = ton_pkg::PH_CR;
               end else if (data_byte == ton_pkg::B_IAC) begin
                  phase_in = ton_pkg::PH_IAC;
               end else begin
                  phase_in = ton_pkg::PH_NORMAL;
               end
            end
            ton_pkg::PH_IAC: begin
               unique case (data_byte)
                  ton_pkg::B_WILL: phase_in = ton_pkg::PH_WILL;
                  ton_pkg::B_WONT: phase_in = ton_pkg::PH_WONT;
                  ton_pkg::B_DO:   phase_in = ton_pkg::PH_DO;
                  ton_pkg::B_DONT: phase_in = ton_pkg::PH_DONT;
                  default:         phase_in = ton_pkg::PH_NORMAL;
               endcase
            end
            default: phase_in = ton_pkg::PH_NORMAL;
         endcase
      end
   end

   // Job built from the beat and the current phase.
   always_comb begin
      job          = '0;
      done_in      = done_ff;
      job.bytes[0] = data_byte;
      if (!done_ff) begin
         unique case (action)
            ton_pkg::ACT_START: begin
               job.to_net = 1'b1;
               job.count  = 3'd6;
               job.bytes  = {ton_pkg::OPT_SGA, ton_pkg::B_DO, ton_pkg::B_IAC,
                             ton_pkg::OPT_ECHO, ton_pkg::B_DO, ton_pkg::B_IAC};
            end
            ton_pkg::ACT_KBD: begin
               job.to_net = 1'b1;
               if (data_byte == ton_pkg::B_LF) begin
                  job.count    = 3'd2;
                  job.bytes[0] = ton_pkg::B_CR;
                  job.bytes[1] = ton_pkg::B_LF;
               end else begin
                  job.count = 3'd1;
               end
            end
            ton_pkg::ACT_NET: begin
               unique case (phase_ff)
                  ton_pkg::PH_NORMAL: begin
                     if (data_byte != ton_pkg::B_CR && data_byte != ton_pkg::B_IAC) begin
                        job.count = 3'd1;
                     end
                  end
                  ton_pkg::PH_CR: begin
                     job.bytes[0] = ton_pkg::B_CR;
                     if (data_byte == ton_pkg::B_LF) begin
                        job.count    = 3'd1;
                        job.bytes[0] = ton_pkg::B_LF;
                     end else if (data_byte == ton_pkg::B_CR ||
                                  data_byte == ton_pkg::B_IAC) begin
                        job.count = 3'd1;
                     end else begin
                        job.count    = 3'd2;
                        job.bytes[1] = data_byte;
                     end
                  end
                  ton_pkg::PH_IAC: begin
                     if (data_byte == ton_pkg::B_IAC) begin
                        job.count = 3'd1;
                     end
                  end
                  ton_pkg::PH_WILL: begin
                     job.to_net   = 1'b1;
                     job.bytes[0] = ton_pkg::B_IAC;
                     job.bytes[2] = data_byte;
                     if (data_byte == tunnel_ff) begin
                        job.count    = 3'd3;
                        job.bytes[1] = ton_pkg::B_DO;
                        job.finished = 1'b1;
                        done_in      = 1'b1;
                     end else if (data_byte != ton_pkg::OPT_ECHO &&
                                  data_byte != ton_pkg::OPT_SGA) begin
                        job.count    = 3'd3;
                        job.bytes[1] = ton_pkg::B_DONT;
                     end
                  end
                  ton_pkg::PH_WONT: begin
                     job.to_net   = 1'b1;
                     job.bytes[0] = ton_pkg::B_IAC;
                     job.bytes[1] = ton_pkg::B_DO;
                     job.bytes[2] = data_byte;
                     if (data_byte == ton_pkg::OPT_ECHO || data_byte == ton_pkg::OPT_SGA) begin
                        job.count = 3'd3;
                     end
                  end
                  ton_pkg::PH_DO: begin
                     job.to_net   = 1'b1;
                     job.bytes[0] = ton_pkg::B_IAC;
                     job.bytes[1] = ton_pkg::B_WONT;
                     job.bytes[2] = data_byte;
                     if (data_byte != ton_pkg::OPT_SGA) begin
                        job.count = 3'd3;
                     end
                  end
                  default: job.count = 3'd0;
               endcase
            end
            default: job.count = 3'd0;
         endcase
      end
   end

   // Beats that produce nothing are consumed here and never queued.
   assign job_valid = accept && (job.count != 3'd0);

endmodule

[design/ton_job_queue.sv]
// ----------------------------------------------------------------------------
// Telnet option negotiator job queue
// Small register queue of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module ton_job_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ton_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output ton_pkg::job_type head_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   ton_pkg::job_type       slots_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]       count_ff;
   logic                   do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[design/ton_back.sv]
// ----------------------------------------------------------------------------
// Telnet option negotiator back end
// Walks the head job one byte per cycle into the result register while the response side keeps popping.
// ----------------------------------------------------------------------------
module ton_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  ton_pkg::job_type job,
   output logic             job_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic             rsp_to_network,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic             rsp_finished
);

   logic       valid_ff, valid_in;
   logic [2:0] idx_ff, idx_in;
   logic       load, last_beat;

   assign load      = job_valid && (!valid_ff || rsp_pop);
   assign last_beat = (idx_ff == job.count - 3'd1);
   assign job_pop   = load && last_beat;
   assign rsp_empty = !valid_ff;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last_beat ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_to_network <= job.to_net;
         rsp_out_byte   <= job.bytes[idx_ff];
         rsp_last       <= last_beat;
         rsp_finished   <= job.finished;
      end
   end

endmodule
